// File: rtl/core/trm_pkg.sv
// ----------------------------------------------------------------------------
// trm_pkg
// shared types and opcodes of the register machine execute core
// ----------------------------------------------------------------------------
package trm_pkg;

   typedef logic [2:0]        cmd_type;
   typedef logic [5:0]        index_type;
   typedef logic signed [31:0] word_type;

   // width of an index widened by one bit for the range compare
   localparam int INDEX_CMP_W = 7;

   // opcodes, codes 6 and 7 do nothing
   localparam cmd_type CMD_LDV = 3'd0;
   localparam cmd_type CMD_SWP = 3'd1;
   localparam cmd_type CMD_MOV = 3'd2;
   localparam cmd_type CMD_ADD = 3'd3;
   localparam cmd_type CMD_SUB = 3'd4;
   localparam cmd_type CMD_MUL = 3'd5;

   // register file write: port 0 goes to bank a, port 1 to bank b
   typedef struct packed {
      logic      en0;
      index_type addr0;
      word_type  data0;
      logic      en1;
      index_type addr1;
      word_type  data1;
   } wr_type;

   typedef struct packed {
      word_type dest_value;
      word_type src_value;
      logic     range_error;
   } result_type;

endpackage

// File: rtl/core/trm_req_if.sv
// ----------------------------------------------------------------------------
// trm_req_if
// instruction channel: valid/ready handshake with one instruction per item
// ----------------------------------------------------------------------------
interface trm_req_if;

   logic                valid;
   logic                ready;
   trm_pkg::cmd_type    cmd;
   trm_pkg::index_type  dest_index;
   trm_pkg::index_type  src_index;
   trm_pkg::word_type   immediate;

   modport source (output valid, output cmd, output dest_index, output src_index,
                   output immediate, input ready);
   modport sink   (input valid, input cmd, input dest_index, input src_index,
                   input immediate, output ready);

endinterface

// File: rtl/core/trm_rsp_if.sv
// ----------------------------------------------------------------------------
// trm_rsp_if
// result channel: valid/ready handshake with both register values and error
// ----------------------------------------------------------------------------
interface trm_rsp_if;

   logic               valid;
   logic               ready;
   trm_pkg::word_type  dest_value;
   trm_pkg::word_type  src_value;
   logic               range_error;

   modport source (output valid, output dest_value, output src_value,
                   output range_error, input ready);
   modport sink   (input valid, input dest_value, input src_value,
                   input range_error, output ready);

endinterface

// File: rtl/core/trm_regfile.sv
// ----------------------------------------------------------------------------
// trm_regfile
// two-bank register file with live-value bits, valid bits and write bypass
// ----------------------------------------------------------------------------
module trm_regfile #(
   parameter int NUM_REGS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  trm_pkg::index_type  rd_dest_idx,
   input  trm_pkg::index_type  rd_src_idx,
   input  trm_pkg::wr_type     wr,
   output trm_pkg::word_type   dest_operand,
   output trm_pkg::word_type   src_operand
);
   import trm_pkg::*;

   localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

   word_type bank_a_mem [NUM_REGS];
   word_type bank_b_mem [NUM_REGS];

   logic [NUM_REGS-1:0] valid_ff;
   logic [NUM_REGS-1:0] lvt_ff;

   word_type  a_dest_ff, a_src_ff, b_dest_ff, b_src_ff;
   logic      vld_dest_ff, vld_src_ff, sel_dest_ff, sel_src_ff;
   index_type dest_idx_ff, src_idx_ff;
   wr_type    fwd_ff;

   logic [IDX_W-1:0] rd_d, rd_s, wr_0, wr_1;

   assign rd_d = rd_dest_idx[IDX_W-1:0];
   assign rd_s = rd_src_idx[IDX_W-1:0];
   assign wr_0 = wr.addr0[IDX_W-1:0];
   assign wr_1 = wr.addr1[IDX_W-1:0];

   // banks: read data registered at accept, old data on a same-edge write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         a_dest_ff   <= bank_a_mem[rd_d];
         a_src_ff    <= bank_a_mem[rd_s];
         b_dest_ff   <= bank_b_mem[rd_d];
         b_src_ff    <= bank_b_mem[rd_s];
         vld_dest_ff <= valid_ff[rd_d];
         vld_src_ff  <= valid_ff[rd_s];
         sel_dest_ff <= lvt_ff[rd_d];
         sel_src_ff  <= lvt_ff[rd_s];
         dest_idx_ff <= rd_dest_idx;
         src_idx_ff  <= rd_src_idx;
      end
      if (wr.en0) begin
         bank_a_mem[wr_0] <= wr.data0;
      end
      if (wr.en1) begin
         bank_b_mem[wr_1] <= wr.data1;
      end
   end

   // live-value bits: which bank holds the newest copy
   always_ff @(posedge clock) begin
      if (wr.en0) begin
         lvt_ff[wr_0] <= 1'b0;
      end
      if (wr.en1) begin
         lvt_ff[wr_1] <= 1'b1;
      end
   end

   // valid bits: unwritten registers read as zero after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (wr.en0) begin
            valid_ff[wr_0] <= 1'b1;
         end
         if (wr.en1) begin
            valid_ff[wr_1] <= 1'b1;
         end
      end
   end

   // last write, bypassed to an item that read the banks on the same edge
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= '0;
      end else if (wr.en0) begin
         fwd_ff <= wr;
      end
   end

   function automatic word_type resolve(index_type idx, wr_type f, logic vld,
                                        logic sel, word_type a_data,
                                        word_type b_data);
      word_type r;
      if (f.en1 && f.addr1 == idx) begin
         r = f.data1;
      end else if (f.en0 && f.addr0 == idx) begin
         r = f.data0;
      end else if (vld) begin
         r = sel ? b_data : a_data;
      end else begin
         r = '0;
      end
      return r;
   endfunction

   assign dest_operand = resolve(dest_idx_ff, fwd_ff, vld_dest_ff, sel_dest_ff,
                                 a_dest_ff, b_dest_ff);
   assign src_operand  = resolve(src_idx_ff, fwd_ff, vld_src_ff, sel_src_ff,
                                 a_src_ff, b_src_ff);

endmodule

// File: rtl/core/trm_exec.sv
// ----------------------------------------------------------------------------
// trm_exec
// range check, operation and register file write for one instruction
// ----------------------------------------------------------------------------
module trm_exec #(
   parameter int NUM_REGS = 32
) (
   input  trm_pkg::cmd_type    cmd,
   input  trm_pkg::index_type  dest_index,
   input  trm_pkg::index_type  src_index,
   input  trm_pkg::word_type   immediate,
   input  trm_pkg::word_type   dest_operand,
   input  trm_pkg::word_type   src_operand,
   output trm_pkg::result_type result,
   output trm_pkg::wr_type     wr
);
   import trm_pkg::*;

   localparam logic [INDEX_CMP_W-1:0] REG_LIMIT = INDEX_CMP_W'(NUM_REGS);

   logic     dest_ok, src_ok, bad, same;
   word_type sum, diff, prod;

   assign dest_ok = {1'b0, dest_index} < REG_LIMIT;
   assign src_ok  = {1'b0, src_index} < REG_LIMIT;
   assign bad     = !dest_ok || (cmd != CMD_LDV && !src_ok);
   assign same    = dest_index == src_index;

   assign sum  = dest_operand + src_operand;
   assign diff = dest_operand - src_operand;
   assign prod = dest_operand * src_operand;   // low 32 bits of the product

   always_comb begin
      result.range_error = 1'b0;
      result.dest_value  = dest_operand;
      result.src_value   = src_operand;
      wr = '0;
      case (cmd)
         CMD_LDV: begin
            result.dest_value = immediate;
            result.src_value  = !src_ok ? '0 : (same ? immediate : src_operand);
            wr.en0   = 1'b1;
            wr.addr0 = dest_index;
            wr.data0 = immediate;
         end
         CMD_SWP: begin
            result.dest_value = src_operand;
            result.src_value  = dest_operand;
            wr.en0   = 1'b1;
            wr.addr0 = dest_index;
            wr.data0 = src_operand;
            // second port only when the two registers differ
            wr.en1   = !same;
            wr.addr1 = src_index;
            wr.data1 = dest_operand;
         end
         CMD_MOV: begin
            // copies destination into source
            result.src_value = dest_operand;
            wr.en0   = 1'b1;
            wr.addr0 = src_index;
            wr.data0 = dest_operand;
         end
         CMD_ADD, CMD_SUB, CMD_MUL: begin
            if (cmd == CMD_ADD) begin
               result.dest_value = sum;
            end else if (cmd == CMD_SUB) begin
               result.dest_value = diff;
            end else begin
               result.dest_value = prod;
            end
            result.src_value = same ? result.dest_value : src_operand;
            wr.en0   = 1'b1;
            wr.addr0 = dest_index;
            wr.data0 = result.dest_value;
         end
         default: begin
         end
      endcase
      if (bad) begin
         result.range_error = 1'b1;
         result.dest_value  = '0;
         result.src_value   = '0;
         wr = '0;
      end
   end

endmodule

// File: rtl/core/tiny_register_machine_execute_core.sv
// ----------------------------------------------------------------------------
// tiny_register_machine_execute_core
// executes one two-operand instruction per item on a 32-bit register file
// ----------------------------------------------------------------------------
// usage
//   req carries one instruction per item: cmd, dest_index, src_index and
//   immediate; rsp returns one item per instruction with both named
//   registers after the step and range_error
//   an accepted item is held in the execute stage and moves on into the
//   result register, which drives rsp.valid, once that register is free
//   or being emptied
//   throughput is one item per cycle while rsp does not stall, set by
//   the single execute stage: banks are read on the accept edge and
//   written on the edge the item moves to the result register, with a
//   one-deep bypass covering the item that follows directly
//   swap writes two registers at once, one per bank, and a live-value
//   bit per register picks the newer bank on read
//   reset clears the valid bits so every register reads as zero at once,
//   no clearing pass is needed
//   when rsp stalls, the result register holds and the execute stage
//   still takes one more item, after which req.ready drops
// ----------------------------------------------------------------------------
module tiny_register_machine_execute_core #(
   parameter int NUM_REGS = 32
) (
   input logic       clock,
   input logic       reset,
   trm_req_if.sink   req,
   trm_rsp_if.source rsp
);
   import trm_pkg::*;

   // execute stage holding the accepted instruction
   logic       s1_valid_ff, s1_valid_in;
   cmd_type    s1_cmd_ff;
   index_type  s1_dest_ff, s1_src_ff;
   word_type   s1_imm_ff;

   // result register
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;

   logic       accept, advance;
   word_type   dest_operand, src_operand;
   result_type exec_result;
   wr_type     exec_wr, commit_wr;

   // stage moves on when the result register is free or being emptied
   assign advance    = s1_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready  = !s1_valid_ff || advance;
   assign accept     = req.valid && req.ready;

   assign s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign out_valid_in = advance ? 1'b1 : ((out_valid_ff && rsp.ready) ? 1'b0
                                                                      : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers need no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff  <= req.cmd;
         s1_dest_ff <= req.dest_index;
         s1_src_ff  <= req.src_index;
         s1_imm_ff  <= req.immediate;
      end
      if (advance) begin
         out_ff <= exec_result;
      end
   end

   // register file state changes only when the item leaves the stage
   always_comb begin
      commit_wr     = exec_wr;
      commit_wr.en0 = exec_wr.en0 && advance;
      commit_wr.en1 = exec_wr.en1 && advance;
   end

   trm_regfile #(
      .NUM_REGS (NUM_REGS)
   ) u_regfile (
      .clock        (clock),
      .reset        (reset),
      .rd_en        (accept),
      .rd_dest_idx  (req.dest_index),
      .rd_src_idx   (req.src_index),
      .wr           (commit_wr),
      .dest_operand (dest_operand),
      .src_operand  (src_operand)
   );

   trm_exec #(
      .NUM_REGS (NUM_REGS)
   ) u_exec (
      .cmd          (s1_cmd_ff),
      .dest_index   (s1_dest_ff),
      .src_index    (s1_src_ff),
      .immediate    (s1_imm_ff),
      .dest_operand (dest_operand),
      .src_operand  (src_operand),
      .result       (exec_result),
      .wr           (exec_wr)
   );

   assign rsp.valid       = out_valid_ff;
   assign rsp.dest_value  = out_ff.dest_value;
   assign rsp.src_value   = out_ff.src_value;
   assign rsp.range_error = out_ff.range_error;

endmodule

// File: verif/tb_tiny_register_machine_execute_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tiny_register_machine_execute_core
// drives instructions into the execute core and checks every result against
// a shadow register file kept by a small scoreboard class; a directed set
// covers the extremes and the error cases, then about 1150 random
// instructions run under three idle and stall patterns
// ----------------------------------------------------------------------------
module tb_tiny_register_machine_execute_core;

   import trm_pkg::*;

   localparam int REG_COUNT     = 32;
   // cycles with no item moving on either channel before the run is abandoned
   localparam int STALL_LIMIT   = 4000;
   localparam int RANDOM_ITEMS  = 1150;
   // cycles allowed after the last result for stray items to show up
   localparam int DRAIN_CYCLES  = 8;

   // no-operation codes, not named in the package
   localparam cmd_type CMD_NOP_LO = 3'd6;
   localparam cmd_type CMD_NOP_HI = 3'd7;

   localparam word_type WORD_MAX = 32'sh7fff_ffff;
   localparam word_type WORD_MIN = 32'sh8000_0000;

   typedef struct {
      cmd_type   cmd;
      index_type dest;
      index_type src;
      word_type  imm;
   } instr_fields_type;

   // ------------------------------------------------------------------------
   // scoreboard: shadow register file plus the queue of pending results
   // ------------------------------------------------------------------------
   class exec_scoreboard;
      word_type   reg_shadow[REG_COUNT];
      result_type expected_q[$];
      int         fail_count;
      int         result_count;

      function new();
         foreach (reg_shadow[i]) reg_shadow[i] = '0;
         fail_count   = 0;
         result_count = 0;
      endfunction

      // runs one instruction on the shadow file and returns what rsp must show
      function result_type execute_instr(instr_fields_type ins);
         result_type r;
         word_type   a;
         word_type   b;
         bit         src_ok;
         bit         bad;
         src_ok = int'(ins.src) < REG_COUNT;
         bad    = (int'(ins.dest) >= REG_COUNT) || (ins.cmd != CMD_LDV && !src_ok);
         r = '0;
         if (bad) begin
            r.range_error = 1'b1;
            return r;
         end
         // both operands are read before any write, so same-register cases fall out
         a = reg_shadow[ins.dest];
         b = src_ok ? reg_shadow[ins.src] : '0;
         case (ins.cmd)
            CMD_LDV: reg_shadow[ins.dest] = ins.imm;
            CMD_SWP: begin
               reg_shadow[ins.dest] = b;
               reg_shadow[ins.src]  = a;
            end
            CMD_MOV: reg_shadow[ins.src]  = a;
            CMD_ADD: reg_shadow[ins.dest] = a + b;
            CMD_SUB: reg_shadow[ins.dest] = a - b;
            CMD_MUL: reg_shadow[ins.dest] = a * b;
            default: ;
         endcase
         r.dest_value = reg_shadow[ins.dest];
         r.src_value  = src_ok ? reg_shadow[ins.src] : '0;
         return r;
      endfunction

      task report_mismatch(string msg);
         fail_count++;
         $display("mismatch at result %0d: %s", result_count, msg);
      endtask

      task note_instr(instr_fields_type ins);
         expected_q.push_back(execute_instr(ins));
      endtask

      task check_result(word_type dest_value, word_type src_value, logic range_error);
         result_type e;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected item dest %h src %h err %b",
                                      dest_value, src_value, range_error));
            return;
         end
         e = expected_q.pop_front();
         if (dest_value !== e.dest_value)
            report_mismatch($sformatf("dest_value %h, want %h", dest_value, e.dest_value));
         if (src_value !== e.src_value)
            report_mismatch($sformatf("src_value %h, want %h", src_value, e.src_value));
         if (range_error !== e.range_error)
            report_mismatch($sformatf("range_error %b, want %b", range_error, e.range_error));
         result_count++;
      endtask
   endclass

   // ------------------------------------------------------------------------
   // clock, reset, channels and the block
   // ------------------------------------------------------------------------
   logic clock;
   logic reset;

   trm_req_if req_bus ();
   trm_rsp_if rsp_bus ();

   tiny_register_machine_execute_core #(
      .NUM_REGS (REG_COUNT)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   exec_scoreboard sb;

   // idle percentages for the sender and the receiver, changed between phases
   int send_idle_pct;
   int recv_stall_pct;
   int send_burst;
   int recv_burst;
   int stuck_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // monitor and watchdog: everything sampled at the rising edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      instr_fields_type seen;
      if (reset) begin
         stuck_cycles <= 0;
      end else begin
         // note the instruction before checking, the result can never share its edge
         if (req_bus.valid && req_bus.ready) begin
            seen.cmd  = req_bus.cmd;
            seen.dest = req_bus.dest_index;
            seen.src  = req_bus.src_index;
            seen.imm  = req_bus.immediate;
            sb.note_instr(seen);
         end
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result(rsp_bus.dest_value, rsp_bus.src_value, rsp_bus.range_error);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            stuck_cycles <= 0;
         end else if (stuck_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
         end else begin
            stuck_cycles <= stuck_cycles + 1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // receiver: random stalls with the odd stretch of steady ready
   // ------------------------------------------------------------------------
   initial begin
      rsp_bus.ready = 1'b0;
      recv_burst    = 0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_bus.ready = 1'b0;
         end else if (recv_burst > 0) begin
            rsp_bus.ready = 1'b1;
            recv_burst--;
         end else if ($urandom_range(0, 63) == 0) begin
            rsp_bus.ready = 1'b1;
            recv_burst    = $urandom_range(8, 40);
         end else begin
            rsp_bus.ready = ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic instr_fields_type mk(cmd_type c, int d, int s, word_type imm);
      instr_fields_type ins;
      ins.cmd  = c;
      ins.dest = index_type'(d);
      ins.src  = index_type'(s);
      ins.imm  = imm;
      return ins;
   endfunction

   // in-range indices most of the time, often bunched low so registers get reused
   function automatic index_type pick_index();
      if ($urandom_range(0, 99) >= 88)
         return index_type'($urandom_range(REG_COUNT, 63));
      if ($urandom_range(0, 3) == 0)
         return index_type'($urandom_range(0, 3));
      return index_type'($urandom_range(0, REG_COUNT - 1));
   endfunction

   function automatic instr_fields_type rand_instr();
      instr_fields_type ins;
      int               roll;
      roll = $urandom_range(0, 99);
      if (roll < 18)      ins.cmd = CMD_LDV;
      else if (roll < 30) ins.cmd = CMD_SWP;
      else if (roll < 42) ins.cmd = CMD_MOV;
      else if (roll < 58) ins.cmd = CMD_ADD;
      else if (roll < 72) ins.cmd = CMD_SUB;
      else if (roll < 88) ins.cmd = CMD_MUL;
      else                ins.cmd = $urandom_range(0, 1) ? CMD_NOP_HI : CMD_NOP_LO;
      ins.dest = pick_index();
      ins.src  = ($urandom_range(0, 9) == 0) ? ins.dest : pick_index();
      case ($urandom_range(0, 19))
         0:       ins.imm = WORD_MAX;
         1:       ins.imm = WORD_MIN;
         2:       ins.imm = -1;
         3:       ins.imm = '0;
         default: ins.imm = word_type'($urandom);
      endcase
      return ins;
   endfunction

   // one instruction on req, with random idle cycles carrying junk payload
   task automatic send_instr(instr_fields_type ins);
      @(negedge clock);
      if (send_burst > 0) begin
         send_burst--;
      end else if ($urandom_range(0, 39) == 0) begin
         send_burst = $urandom_range(10, 30);
      end else begin
         while ($urandom_range(0, 99) < send_idle_pct) begin
            req_bus.valid      = 1'b0;
            req_bus.cmd        = cmd_type'($urandom);
            req_bus.dest_index = index_type'($urandom);
            req_bus.src_index  = index_type'($urandom);
            req_bus.immediate  = word_type'($urandom);
            @(negedge clock);
         end
      end
      req_bus.valid      = 1'b1;
      req_bus.cmd        = ins.cmd;
      req_bus.dest_index = ins.dest;
      req_bus.src_index  = ins.src;
      req_bus.immediate  = ins.imm;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      int per_phase;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.cmd        = CMD_LDV;
      req_bus.dest_index = '0;
      req_bus.src_index  = '0;
      req_bus.immediate  = '0;
      send_idle_pct      = 25;
      recv_stall_pct     = 53;
      send_burst         = 0;
      sb                 = new();
      per_phase          = RANDOM_ITEMS / 3;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, every operation, same-register and error cases
      send_instr(mk(CMD_LDV, 0, 0, WORD_MAX));
      send_instr(mk(CMD_LDV, 31, 63, WORD_MIN));   // load ignores an out-of-range source
      send_instr(mk(CMD_LDV, 1, 31, -1));
      send_instr(mk(CMD_LDV, 2, 1, '0));
      send_instr(mk(CMD_ADD, 0, 1, '0));           // max plus minus one
      send_instr(mk(CMD_ADD, 31, 31, '0));         // min doubled wraps to zero
      send_instr(mk(CMD_LDV, 31, 0, WORD_MIN));
      send_instr(mk(CMD_SUB, 2, 31, '0));          // zero minus min wraps
      send_instr(mk(CMD_SUB, 1, 1, '0));           // same register clears
      send_instr(mk(CMD_LDV, 3, 0, 32'sh1234_5678));
      send_instr(mk(CMD_MUL, 3, 0, '0));
      send_instr(mk(CMD_MUL, 3, 3, '0));           // same register squares
      send_instr(mk(CMD_SWP, 0, 3, '0));
      send_instr(mk(CMD_SWP, 5, 5, '0));
      send_instr(mk(CMD_MOV, 0, 4, '0));           // copies dest into src
      send_instr(mk(CMD_MOV, 7, 7, '0));
      send_instr(mk(CMD_NOP_LO, 0, 3, -1));
      send_instr(mk(CMD_NOP_HI, 31, 31, WORD_MAX));
      send_instr(mk(CMD_LDV, 32, 0, WORD_MAX));    // destination out of range
      send_instr(mk(CMD_ADD, 0, 63, '0));          // source out of range
      send_instr(mk(CMD_SWP, 63, 0, '0));
      send_instr(mk(CMD_NOP_LO, 5, 40, '0));       // nop still checks its indices
      send_instr(mk(CMD_MUL, 0, 31, '0));
      send_instr(mk(CMD_LDV, 0, 42, 32'sh0000_0001));
      send_instr(mk(CMD_SUB, 0, 3, '0));

      // random, under three idle patterns
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 25;
               recv_stall_pct = 53;
            end
            1: begin
               send_idle_pct  = 53;
               recv_stall_pct = 25;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         for (int n = 0; n < per_phase + ((phase == 2) ? RANDOM_ITEMS % 3 : 0); n++)
            send_instr(rand_instr());
      end

      @(negedge clock);
      req_bus.valid = 1'b0;

      // the watchdog bounds both waits
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.fail_count == 0 && sb.expected_q.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
